// ===== hdl/motor_command_packet_handler_core_assert.svh =====
// Assertion macros shared by the checker of the motor command packet handler.
`ifndef MOTOR_COMMAND_PACKET_HANDLER_CORE_ASSERT_SVH
`define MOTOR_COMMAND_PACKET_HANDLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCPH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/mcph_pkg.sv =====
// Package with the constants, types and CRC-32 functions of the motor command handler.
`default_nettype none

package mcph_pkg;

  localparam int unsigned MaxPacketBytesDef = 1024;
  localparam int unsigned MinPacketBytes    = 12;

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcAllOnes  = 32'hFFFF_FFFF;
  localparam logic [31:0] BoardMask   = 32'h0300_0000;
  localparam logic [31:0] CmdFlag     = 32'h0020_0000;
  localparam logic [31:0] ReplyHeader = 32'h0410_0000;

  localparam logic signed [31:0] TargetReset = 32'sd100;

  localparam logic [3:0] CmdStatus = 4'd0;
  localparam logic [3:0] CmdAdd    = 4'd1;
  localparam logic [3:0] CmdSub    = 4'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OK,
    PH_CRC
  } reply_phase_t;

  // One entry of the reflected CRC-32 table.
  function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_table_entry(crc[7:0] ^ b);
  endfunction

  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc_byte(crc, w[31:24]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[15:8]);
    return crc_byte(c, w[7:0]);
  endfunction

  function automatic logic [31:0] reply_header(input logic ok);
    return ReplyHeader | {9'd0, ok, 22'd0};
  endfunction

  function automatic logic [31:0] reply_crc(input logic ok);
    return crc_word(crc_word(CrcAllOnes, reply_header(ok)), {31'd0, ok}) ^ CrcAllOnes;
  endfunction

  localparam logic [31:0] ReplyCrcOk   = reply_crc(1'b1);
  localparam logic [31:0] ReplyCrcFail = reply_crc(1'b0);

endpackage

`default_nettype wire

// ===== hdl/mcph_rx_if.sv =====
// Byte stream channel that carries the received packet.
`default_nettype none

interface mcph_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcph_reply_if.sv =====
// Word stream channel that carries the reply and the stepper target.
`default_nettype none

interface mcph_reply_if;
  logic               valid;
  logic               ready;
  logic [31:0]        reply_word;
  logic               reply_last;
  logic signed [31:0] target_position;

  modport source (output valid, output reply_word, output reply_last,
                  output target_position, input ready);
  modport sink   (input valid, input reply_word, input reply_last,
                  input target_position, output ready);
endinterface

`default_nettype wire

// ===== hdl/motor_command_packet_handler_core.sv =====
// Motor command handler: takes one packet byte per cycle and checks the CRC-32
// of the frame on its last byte. A valid command updates the signed stepper
// target, and a three-word reply (header, ok, CRC-32) follows on the reply
// channel, with the target after that packet on every word. Bytes are taken
// at one per cycle; the CRC table step, the frame check and the target add all
// happen in the cycle a byte is accepted. Each reply occupies the output for
// three accepted words and one finished reply can wait behind the one being
// sent, so input stalls only while two replies are pending, which takes a run
// of packets shorter than three bytes or a reply sink that holds off ready.
`default_nettype none

module motor_command_packet_handler_core
  import mcph_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDef
) (
  input  logic          clk,
  input  logic          rst,
  mcph_rx_if.sink       rx,
  mcph_reply_if.source  reply
);

  localparam int unsigned CountW = $clog2(MAX_PACKET_BYTES + 2);
  localparam logic [CountW-1:0] CountSat    = CountW'(MAX_PACKET_BYTES + 1);
  localparam logic [CountW-1:0] CountMax    = CountW'(MAX_PACKET_BYTES);
  localparam logic [CountW-1:0] CountMin    = CountW'(MinPacketBytes);
  localparam logic [CountW-1:0] CountHeader = CountW'(4);
  localparam logic [CountW-1:0] CountMag    = CountW'(8);

  // Packet state.
  logic [31:0]        running_crc;
  logic [31:0]        tail_window;
  logic [CountW-1:0]  byte_count;
  logic [31:0]        header_word;
  logic [31:0]        magnitude_word;
  logic signed [31:0] stepper_target;

  // Reply being sent and one reply waiting behind it.
  logic               active_valid;
  logic               active_ok;
  logic signed [31:0] active_target;
  reply_phase_t       active_phase;
  logic               queued_valid;
  logic               queued_ok;
  logic signed [31:0] queued_target;

  logic               rx_fire;
  logic               reply_push;
  logic               reply_fire;
  logic               reply_done;
  logic [31:0]        crc_next;
  logic [31:0]        tail_next;
  logic [CountW-1:0]  count_next;
  logic               frame_ok;
  logic               cmd_ok;
  logic signed [31:0] cmd_target;
  logic               packet_ok;
  logic signed [31:0] target_next;

  assign rx.ready   = !rst && !queued_valid;
  assign rx_fire    = rx.valid && rx.ready;
  assign reply_push = rx_fire && rx.end_of_packet;
  assign reply_fire = reply.valid && reply.ready;
  assign reply_done = reply_fire && (active_phase == PH_CRC);

  // The CRC register trails the input by four bytes so the last word is the
  // received checksum and never enters the CRC itself.
  assign crc_next   = (byte_count >= CountHeader) ?
                      crc_byte(running_crc, tail_window[31:24]) : running_crc;
  assign tail_next  = {tail_window[23:0], rx.rx_byte};
  assign count_next = (byte_count < CountSat) ? byte_count + CountW'(1) : byte_count;

  // Header and magnitude are already stored whenever the length check passes.
  assign frame_ok = ((crc_next ^ CrcAllOnes) == tail_next)
                 && ((header_word & BoardMask) != 32'd0)
                 && ((header_word & CmdFlag) != 32'd0)
                 && (count_next >= CountMin)
                 && (count_next[1:0] == 2'b00)
                 && (count_next <= CountMax);

  always_comb begin
    case (header_word[19:16])
      CmdStatus: begin
        cmd_ok     = 1'b1;
        cmd_target = stepper_target;
      end
      CmdAdd: begin
        cmd_ok     = 1'b1;
        cmd_target = stepper_target + $signed(magnitude_word);
      end
      CmdSub: begin
        cmd_ok     = 1'b1;
        cmd_target = stepper_target - $signed(magnitude_word);
      end
      default: begin
        cmd_ok     = 1'b0;
        cmd_target = stepper_target;
      end
    endcase
  end

  assign packet_ok   = frame_ok && cmd_ok;
  assign target_next = packet_ok ? cmd_target : stepper_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= CrcAllOnes;
      tail_window    <= 32'd0;
      byte_count     <= '0;
      header_word    <= 32'd0;
      magnitude_word <= 32'd0;
      stepper_target <= TargetReset;
    end else if (rx_fire) begin
      if (rx.end_of_packet) begin
        running_crc    <= CrcAllOnes;
        tail_window    <= 32'd0;
        byte_count     <= '0;
        header_word    <= 32'd0;
        magnitude_word <= 32'd0;
        stepper_target <= target_next;
      end else begin
        running_crc <= crc_next;
        tail_window <= tail_next;
        byte_count  <= count_next;
        if (count_next == CountHeader) begin
          header_word <= tail_next;
        end else if (count_next == CountMag) begin
          magnitude_word <= tail_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_valid <= 1'b0;
      active_phase <= PH_HEADER;
      queued_valid <= 1'b0;
    end else begin
      if (!active_valid || reply_done) begin
        active_phase <= PH_HEADER;
        if (queued_valid) begin
          active_valid  <= 1'b1;
          active_ok     <= queued_ok;
          active_target <= queued_target;
          queued_valid  <= 1'b0;
        end else if (reply_push) begin
          active_valid  <= 1'b1;
          active_ok     <= packet_ok;
          active_target <= target_next;
        end else begin
          active_valid <= 1'b0;
        end
      end else begin
        if (reply_fire) begin
          case (active_phase)
            PH_HEADER: active_phase <= PH_OK;
            PH_OK:     active_phase <= PH_CRC;
            default:   active_phase <= PH_HEADER;
          endcase
        end
        if (reply_push) begin
          queued_valid  <= 1'b1;
          queued_ok     <= packet_ok;
          queued_target <= target_next;
        end
      end
    end
  end

  always_comb begin
    case (active_phase)
      PH_HEADER: reply.reply_word = reply_header(active_ok);
      PH_OK:     reply.reply_word = {31'd0, active_ok};
      PH_CRC:    reply.reply_word = active_ok ? ReplyCrcOk : ReplyCrcFail;
      default:   reply.reply_word = 32'd0;
    endcase
  end

  assign reply.valid           = active_valid;
  assign reply.reply_last      = (active_phase == PH_CRC);
  assign reply.target_position = active_target;

endmodule

`default_nettype wire

// ===== hdl/mcph_checker.sv =====
// Port-level checker for the motor command handler and its bind statement.
`default_nettype none

`include "motor_command_packet_handler_core_assert.svh"

module mcph_checker
  import mcph_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        reply_valid,
  input wire logic        reply_ready,
  input wire logic [31:0] reply_word,
  input wire logic        reply_last
);

  logic reply_fire;
  logic word_is_header;

  assign reply_fire     = reply_valid && reply_ready;
  assign word_is_header = (reply_word == reply_header(1'b0))
                       || (reply_word == reply_header(1'b1));

  // A stalled reply word must hold its value.
  `MCPH_ASSERT_NEXT(a_reply_hold, clk, rst, reply_valid && !reply_ready,
    reply_valid && $stable(reply_word) && $stable(reply_last))

  // Words before the last are either a header or an ok value.
  `MCPH_ASSERT_IMPLY(a_body_word, clk, rst, reply_valid && !reply_last,
    word_is_header || (reply_word == 32'd0) || (reply_word == 32'd1))

  // The closing word is always one of the two reply checksums.
  `MCPH_ASSERT_IMPLY(a_crc_word, clk, rst, reply_valid && reply_last,
    (reply_word == ReplyCrcOk) || (reply_word == ReplyCrcFail))

  // After a closing word is taken, the next word shown starts a new reply.
  `MCPH_ASSERT_NEXT(a_reply_restart, clk, rst, reply_fire && reply_last,
    !reply_valid || word_is_header)

endmodule

bind motor_command_packet_handler_core mcph_checker u_mcph_checker (
  .clk         (clk),
  .rst         (rst),
  .reply_valid (reply.valid),
  .reply_ready (reply.ready),
  .reply_word  (reply.reply_word),
  .reply_last  (reply.reply_last)
);

`default_nettype wire
